/* hdl/deque_pkg.sv */
// Shared types and codes for the double-ended queue.
`default_nettype none

package deque_pkg;

   // Command codes carried in a request.
   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_POP_BACK   = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_PEEK_BACK  = 3'd4,
      CMD_PEEK_FRONT = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   // Status codes returned with every result.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Fixed field widths of the channels.
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 9;

   typedef struct packed {
      logic [2:0]               cmd;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/double_ended_queue.sv */
// Bounded double-ended queue held in a ring buffer memory.
`default_nettype none

// The queue takes one request per clock cycle and returns exactly one result
// for each, in order. Each result passes the read stage and the output register:
// the store read is registered at the accepting edge, and the output register
// loads as the read stage drains. Pointers and the occupancy count are updated
// at acceptance, so a request may depend on the one just before it without any
// wait. A stall on the result side holds the pipeline; once the read stage and
// the output register are both occupied, req_stall follows rsp_stall in the
// same cycle. Push when full and pop or peek when empty leave the queue
// unchanged and report a full or empty status with zero data. The store needs
// no initialization pass, since only entries holding live words are read.
module double_ended_queue #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 32
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   output                     logic req_stall,
   input  wire deque_pkg::req_type  req_item,
   output                     logic rsp_valid,
   input  wire                logic rsp_stall,
   output deque_pkg::rsp_type       rsp_item
);
   import deque_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   // Queue state.
   logic [AW-1:0] front_ptr_ff, front_ptr_in;
   logic [AW-1:0] back_ptr_ff, back_ptr_in;
   logic [CW-1:0] occ_ff, occ_in;

   // Store memory and its access controls.
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] mem_rd_ff;
   logic             wr_en;
   logic             rd_en;
   logic [AW-1:0]    mem_addr;
   logic [WIDTH-1:0] wr_word;

   // Read stage: waits for the memory read data.
   logic                s1_valid_ff, s1_valid_in;
   logic [STATUS_W-1:0] s1_status_ff, s1_status_in;
   logic [CW-1:0]       s1_count_ff;
   logic                s1_rd_ok_ff;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic accept;
   logic s1_move;
   logic empty;
   logic full;
   logic [AW-1:0] front_inc, front_dec, back_dec, back_inc;

   logic signed [63:0]       value_ext;
   logic signed [WIDTH-1:0]  rd_word_s;
   logic signed [63:0]       rd_word_ext;

   // Handshake: the read stage drains when the output register is free.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign empty = (occ_ff == '0);
   assign full  = (occ_ff >= FULL_CNT);

   // Pointer steps wrap modulo DEPTH.
   assign front_inc = (front_ptr_ff == LAST_IDX) ? '0 : front_ptr_ff + AW'(1);
   assign front_dec = (front_ptr_ff == '0) ? LAST_IDX : front_ptr_ff - AW'(1);
   assign back_inc  = (back_ptr_ff == LAST_IDX) ? '0 : back_ptr_ff + AW'(1);
   assign back_dec  = (back_ptr_ff == '0) ? LAST_IDX : back_ptr_ff - AW'(1);

   // The pushed word keeps its low WIDTH bits.
   assign value_ext = 64'(req_item.value);
   assign wr_word   = value_ext[WIDTH-1:0];

   // Command decode: next pointers, memory access and status.
   always_comb begin
      front_ptr_in = front_ptr_ff;
      back_ptr_in  = back_ptr_ff;
      occ_in       = occ_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      mem_addr     = back_ptr_ff;
      s1_status_in = ST_OK;
      if (accept) begin
         case (req_item.cmd)
            CMD_PUSH_BACK: begin
               if (full) begin
                  s1_status_in = ST_FULL;
               end else begin
                  wr_en       = 1'b1;
                  mem_addr    = back_ptr_ff;
                  back_ptr_in = back_inc;
                  occ_in      = occ_ff + CW'(1);
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en       = 1'b1;
                  mem_addr    = back_dec;
                  back_ptr_in = back_dec;
                  occ_in      = occ_ff - CW'(1);
               end
            end
            CMD_PUSH_FRONT: begin
               if (full) begin
                  s1_status_in = ST_FULL;
               end else begin
                  wr_en        = 1'b1;
                  mem_addr     = front_dec;
                  front_ptr_in = front_dec;
                  occ_in       = occ_ff + CW'(1);
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en        = 1'b1;
                  mem_addr     = front_ptr_ff;
                  front_ptr_in = front_inc;
                  occ_in       = occ_ff - CW'(1);
               end
            end
            CMD_PEEK_BACK: begin
               if (empty) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  mem_addr = back_dec;
               end
            end
            CMD_PEEK_FRONT: begin
               if (empty) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  mem_addr = front_ptr_ff;
               end
            end
            CMD_CLEAR: begin
               front_ptr_in = '0;
               back_ptr_in  = '0;
               occ_in       = '0;
            end
            default: begin
               // Unused code: no change, status ok.
            end
         endcase
      end
   end

   // Queue state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ptr_ff <= '0;
         back_ptr_ff  <= '0;
         occ_ff       <= '0;
      end else begin
         front_ptr_ff <= front_ptr_in;
         back_ptr_ff  <= back_ptr_in;
         occ_ff       <= occ_in;
      end
   end

   // Store memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[mem_addr] <= wr_word;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[mem_addr];
      end
   end

   // Read stage control.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= s1_status_in;
         s1_count_ff  <= occ_in;
         s1_rd_ok_ff  <= rd_en;
      end
   end

   // Read word is sign-extended from WIDTH bits.
   assign rd_word_s   = mem_rd_ff;
   assign rd_word_ext = 64'(rd_word_s);

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff.data   <= s1_rd_ok_ff ? rd_word_ext[DATA_W-1:0] : '0;
         rsp_ff.status <= s1_status_ff;
         rsp_ff.count  <= COUNT_W'(s1_count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   // The count never passes the capacity.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("occupancy above capacity");

   // A rejected push reports a full queue.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_status_ff == ST_FULL) |-> s1_count_ff == FULL_CNT)
      else $error("full status with queue not full");

   // An empty report always leaves the queue empty.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_status_ff == ST_EMPTY) |-> s1_count_ff == '0)
      else $error("empty status with words stored");

   // Memory reads only happen for successful pops and peeks.
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff && s1_rd_ok_ff && (s1_status_ff == ST_OK))
      else $error("read issued for a failed request");

   // Errors never return data.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != ST_OK) |-> rsp_ff.data == '0)
      else $error("error result with nonzero data");
`endif

endmodule

`default_nettype wire
